// ----- hdl/bmb_pkg.sv -----
// shared types, constants and codes for the bipartite max biclique unit
// no dependencies
package bmb_pkg;

    localparam int LEFT_MAX_DEF  = 32;
    localparam int RIGHT_MAX_DEF = 32;
    localparam int CFG_W         = 6;

    // action codes of an input beat
    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_ADD   = 2'd1;
    localparam logic [1:0] ACT_SOLVE = 2'd2;

    // configuration register indexes
    localparam logic CFG_LEFT_COUNT  = 1'b0;
    localparam logic CFG_RIGHT_COUNT = 1'b1;

    typedef struct packed {
        logic [1:0] action;
        logic [4:0] left_index;
        logic [4:0] right_index;
        logic [6:0] min_size;
    } t_bmb_in;

    typedef struct packed {
        logic [31:0] left_mask;
        logic [31:0] right_mask;
        logic [6:0]  biclique_size;
        logic        stopped;
    } t_bmb_out;

    typedef struct packed {
        logic clear;
        logic add;
    } t_bmb_store_cmd;

endpackage

// ----- hdl/bmb_edge_store.sv -----
// adjacency row store with per-row valid bits so a clear empties every row at once
// depends on bmb_pkg
module bmb_edge_store #(
    parameter int LEFT_MAX  = 32,
    parameter int RIGHT_MAX = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  bmb_pkg::t_bmb_store_cmd i_cmd,
    input  logic [((LEFT_MAX > 1) ? $clog2(LEFT_MAX) : 1)-1:0]   i_add_row,
    input  logic [((RIGHT_MAX > 1) ? $clog2(RIGHT_MAX) : 1)-1:0] i_add_col,
    input  logic [((LEFT_MAX > 1) ? $clog2(LEFT_MAX) : 1)-1:0]   i_rd_addr,
    output logic [RIGHT_MAX-1:0]    o_rd_row
);
    import bmb_pkg::*;

    logic [RIGHT_MAX-1:0] r_rows [LEFT_MAX];
    logic [LEFT_MAX-1:0]  r_row_v;
    logic [RIGHT_MAX-1:0] n_add_row;

    // read-modify-write of the addressed row, invalid rows read as empty
    assign n_add_row = (r_row_v[i_add_row] ? r_rows[i_add_row] : '0)
                     | (RIGHT_MAX'(1) << i_add_col);

    assign o_rd_row = r_row_v[i_rd_addr] ? r_rows[i_rd_addr] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_v <= '0;
        end else if (i_cmd.clear) begin
            r_row_v <= '0;
        end else if (i_cmd.add) begin
            r_row_v[i_add_row] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.add && !i_cmd.clear) begin
            r_rows[i_add_row] <= n_add_row;
        end
    end

endmodule

// ----- hdl/bmb_match_engine.sv -----
// matching sequencer: alternating-path search and augmentation, one left
// vertex or one path edge per cycle; depends on bmb_pkg
module bmb_match_engine #(
    parameter int LEFT_MAX  = 32,
    parameter int RIGHT_MAX = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_ack,
    input  logic [LEFT_MAX-1:0]  i_lmask,
    input  logic [RIGHT_MAX-1:0] i_rmask,
    output logic [((LEFT_MAX > 1) ? $clog2(LEFT_MAX) : 1)-1:0] o_row_addr,
    input  logic [RIGHT_MAX-1:0] i_row,
    output logic                 o_done,
    output logic [LEFT_MAX-1:0]  o_reached_l,
    output logic [RIGHT_MAX-1:0] o_reached_r,
    output logic [$clog2(LEFT_MAX+1)-1:0] o_match_count
);
    import bmb_pkg::*;

    localparam int LIW = (LEFT_MAX > 1) ? $clog2(LEFT_MAX) : 1;
    localparam int RIW = (RIGHT_MAX > 1) ? $clog2(RIGHT_MAX) : 1;
    localparam int MW  = $clog2(LEFT_MAX + 1);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_INIT    = 3'd1;
    localparam logic [2:0] ST_SEARCH  = 3'd2;
    localparam logic [2:0] ST_AUGMENT = 3'd3;
    localparam logic [2:0] ST_DONE    = 3'd4;

    logic [2:0]           r_state, n_state;
    logic [RIW-1:0]       n_pl [LEFT_MAX];
    logic [LEFT_MAX-1:0]  r_pl_v, n_pl_v;
    logic [LIW-1:0]       r_pr [RIGHT_MAX];
    logic [LIW-1:0]       n_pr [RIGHT_MAX];
    logic [RIGHT_MAX-1:0] r_pr_v, n_pr_v;
    logic [LIW-1:0]       r_par [RIGHT_MAX];
    logic [LIW-1:0]       n_par [RIGHT_MAX];
    logic [LEFT_MAX-1:0]  r_reach_l, n_reach_l, r_done_l, n_done_l;
    logic [RIGHT_MAX-1:0] r_reach_r, n_reach_r;
    logic [RIW-1:0]       r_aug_j, n_aug_j;
    logic [MW-1:0]        r_m, n_m;
    logic [RIW-1:0]       r_plr [LEFT_MAX];

    logic [LEFT_MAX-1:0]  pend, grow_l;
    logic [RIGHT_MAX-1:0] comp, new_r, free_new;
    logic [LIW-1:0]       pick_i, aug_i;
    logic [RIW-1:0]       pick_j;

    // lowest pending left vertex and lowest newly reached free right vertex
    always_comb begin
        pick_i = '0;
        for (int k = LEFT_MAX - 1; k >= 0; k--) begin
            if (pend[k]) pick_i = LIW'(k);
        end
        pick_j = '0;
        for (int k = RIGHT_MAX - 1; k >= 0; k--) begin
            if (free_new[k]) pick_j = RIW'(k);
        end
    end

    assign pend     = r_reach_l & ~r_done_l;
    assign comp     = ~i_row & i_rmask;
    assign new_r    = comp & ~r_reach_r;
    assign free_new = new_r & ~r_pr_v;
    assign aug_i    = r_par[r_aug_j];
    assign o_row_addr = pick_i;

    // matched left vertices whose partner was just reached
    always_comb begin
        for (int k = 0; k < LEFT_MAX; k++) begin
            grow_l[k] = r_pl_v[k] && new_r[r_plr[k]];
        end
    end

    always_comb begin
        n_state   = r_state;
        n_pl      = r_plr;
        n_pl_v    = r_pl_v;
        n_pr      = r_pr;
        n_pr_v    = r_pr_v;
        n_par     = r_par;
        n_reach_l = r_reach_l;
        n_reach_r = r_reach_r;
        n_done_l  = r_done_l;
        n_aug_j   = r_aug_j;
        n_m       = r_m;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_pl_v  = '0;
                    n_pr_v  = '0;
                    n_m     = '0;
                    n_state = ST_INIT;
                end
            end
            ST_INIT: begin
                n_reach_l = i_lmask & ~r_pl_v;
                n_reach_r = '0;
                n_done_l  = '0;
                n_state   = ST_SEARCH;
            end
            ST_SEARCH: begin
                if (pend == '0) begin
                    n_state = ST_DONE;
                end else begin
                    n_done_l[pick_i] = 1'b1;
                    n_reach_r = r_reach_r | new_r;
                    for (int k = 0; k < RIGHT_MAX; k++) begin
                        if (new_r[k]) n_par[k] = pick_i;
                    end
                    if (free_new != '0) begin
                        n_aug_j = pick_j;
                        n_state = ST_AUGMENT;
                    end else begin
                        n_reach_l = r_reach_l | grow_l;
                    end
                end
            end
            ST_AUGMENT: begin
                n_pr[r_aug_j]   = aug_i;
                n_pr_v[r_aug_j] = 1'b1;
                n_pl[aug_i]     = r_aug_j;
                n_pl_v[aug_i]   = 1'b1;
                if (r_pl_v[aug_i]) begin
                    n_aug_j = r_plr[aug_i];
                end else begin
                    n_m     = r_m + MW'(1);
                    n_state = ST_INIT;
                end
            end
            ST_DONE: begin
                if (i_ack) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pl_v  <= '0;
            r_pr_v  <= '0;
            r_m     <= '0;
        end else begin
            r_state <= n_state;
            r_pl_v  <= n_pl_v;
            r_pr_v  <= n_pr_v;
            r_m     <= n_m;
        end
    end

    always_ff @(posedge i_clk) begin
        r_plr     <= n_pl;
        r_pr      <= n_pr;
        r_par     <= n_par;
        r_reach_l <= n_reach_l;
        r_reach_r <= n_reach_r;
        r_done_l  <= n_done_l;
        r_aug_j   <= n_aug_j;
    end

    assign o_done        = (r_state == ST_DONE);
    assign o_reached_l   = r_reach_l;
    assign o_reached_r   = r_reach_r;
    assign o_match_count = r_m;

`ifndef ASSERT_OFF
    // a path flip leaves the two sides one apart until its last step
    a_match_pairs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_AUGMENT) |-> ($countones(r_pl_v) == $countones(r_pr_v)))
        else $error("left and right matched counts differ");
    a_reached_matched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEARCH) |-> ((r_reach_r & ~r_pr_v) == '0))
        else $error("free right vertex reached without augmenting");
    a_done_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> (32'(r_m) == $countones(r_pl_v)))
        else $error("matching counter out of step");
    a_aug_to_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_AUGMENT && !r_pl_v[aug_i]) |=> (r_state == ST_INIT))
        else $error("augmenting path did not close");
`endif

endmodule

// ----- hdl/bipartite_max_biclique_unit.sv -----
// top level of the bipartite max biclique unit: handshakes, config, result
// depends on bmb_pkg, bmb_edge_store, bmb_match_engine
//
// input channel i_valid/o_ready carries a t_bmb_in beat: clear, add edge
// or solve. clear and add give no result beat, so edges stream in at one
// per cycle while no solve is running. an edge outside the current counts is
// dropped. a solve beat drops o_ready until its result is in the output
// register; it runs a matching on the complement graph in the shared
// search step: each matching round is an init step, a search step per left
// vertex scanned (at most left_count) and an augment step per right vertex
// on the augmenting path, for matches + 1 rounds, and a last search step
// sees the search empty. the result beat shows on o_valid/i_ready once
// the result register takes the engine result.
// a stalled receiver holds the result register; a finished solve waits in
// the engine, with o_ready still low, until the register frees. config
// writes on i_cfg_we at any cycle, meant for idle time. reset empties the
// edge store at once (row valid bits) and sets both counts to their maximum.
module bipartite_max_biclique_unit #(
    parameter int LEFT_MAX  = bmb_pkg::LEFT_MAX_DEF,
    parameter int RIGHT_MAX = bmb_pkg::RIGHT_MAX_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  bmb_pkg::t_bmb_in         i_data,
    output logic                     o_valid,
    input  logic                     i_ready,
    output bmb_pkg::t_bmb_out        o_data,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_idx,
    input  logic [bmb_pkg::CFG_W-1:0] i_cfg_data
);
    import bmb_pkg::*;

    localparam int LIW = (LEFT_MAX > 1) ? $clog2(LEFT_MAX) : 1;
    localparam int RIW = (RIGHT_MAX > 1) ? $clog2(RIGHT_MAX) : 1;
    localparam int MW  = $clog2(LEFT_MAX + 1);
    localparam int LP  = (LEFT_MAX > 32) ? LEFT_MAX : 32;
    localparam int RP  = (RIGHT_MAX > 32) ? RIGHT_MAX : 32;

    // counts held one bit wider so a maximum of 64 survives reset
    logic [6:0]     r_left_count, r_right_count;
    logic [6:0]     ln, rn;
    logic           r_busy;
    logic [6:0]     r_min_size;
    logic           r_o_valid;
    t_bmb_out       r_o_data, n_o_data;

    logic           in_acc, solve_go, eng_ack, eng_done;
    t_bmb_store_cmd store_cmd;
    logic [6:0]     li7, ri7;
    logic [LEFT_MAX-1:0]  lmask, lres;
    logic [RIGHT_MAX-1:0] rmask, rres, rd_row, reach_r;
    logic [LEFT_MAX-1:0]  reach_l;
    logic [LIW-1:0] rd_addr;
    logic [MW-1:0]  match_count;
    logic [7:0]     total, size8;
    logic [LP-1:0]  lres_w;
    logic [RP-1:0]  rres_w;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_count  <= 7'(LEFT_MAX);
            r_right_count <= 7'(RIGHT_MAX);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_LEFT_COUNT) r_left_count <= 7'(i_cfg_data);
            if (i_cfg_idx == CFG_RIGHT_COUNT) r_right_count <= 7'(i_cfg_data);
        end
    end

    // zero acts as one, anything above the store size acts as the size
    assign ln = (r_left_count == 7'd0) ? 7'd1 :
                (r_left_count > 7'(LEFT_MAX)) ? 7'(LEFT_MAX) : r_left_count;
    assign rn = (r_right_count == 7'd0) ? 7'd1 :
                (r_right_count > 7'(RIGHT_MAX)) ? 7'(RIGHT_MAX) : r_right_count;

    always_comb begin
        for (int k = 0; k < LEFT_MAX; k++) lmask[k] = (7'(k) < ln);
        for (int k = 0; k < RIGHT_MAX; k++) rmask[k] = (7'(k) < rn);
    end

    // input beat decode
    assign o_ready  = !r_busy;
    assign in_acc   = i_valid && o_ready;
    assign li7      = 7'(i_data.left_index);
    assign ri7      = 7'(i_data.right_index);
    assign solve_go = in_acc && (i_data.action == ACT_SOLVE);
    assign store_cmd.clear = in_acc && (i_data.action == ACT_CLEAR);
    assign store_cmd.add   = in_acc && (i_data.action == ACT_ADD)
                           && (li7 < ln) && (ri7 < rn);

    bmb_edge_store #(
        .LEFT_MAX  (LEFT_MAX),
        .RIGHT_MAX (RIGHT_MAX)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (store_cmd),
        .i_add_row (li7[LIW-1:0]),
        .i_add_col (ri7[RIW-1:0]),
        .i_rd_addr (rd_addr),
        .o_rd_row  (rd_row)
    );

    bmb_match_engine #(
        .LEFT_MAX  (LEFT_MAX),
        .RIGHT_MAX (RIGHT_MAX)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (solve_go),
        .i_ack         (eng_ack),
        .i_lmask       (lmask),
        .i_rmask       (rmask),
        .o_row_addr    (rd_addr),
        .i_row         (rd_row),
        .o_done        (eng_done),
        .o_reached_l   (reach_l),
        .o_reached_r   (reach_r),
        .o_match_count (match_count)
    );

    // the result register takes the engine result once it is free
    assign eng_ack = eng_done && (!r_o_valid || i_ready);

    // biclique size is the vertex total less the matching size (koenig)
    assign lres   = reach_l & lmask;
    assign rres   = ~reach_r & rmask;
    assign lres_w = LP'(lres);
    assign rres_w = RP'(rres);
    assign total  = 8'(ln) + 8'(rn);
    assign size8  = total - 8'(match_count);

    always_comb begin
        if ((8'(r_min_size) <= total) && (size8 < 8'(r_min_size))) begin
            n_o_data = '0;
            n_o_data.stopped = 1'b1;
        end else begin
            n_o_data.left_mask     = lres_w[31:0];
            n_o_data.right_mask    = rres_w[31:0];
            n_o_data.biclique_size = size8[6:0];
            n_o_data.stopped       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (solve_go) begin
                r_busy <= 1'b1;
            end else if (eng_ack) begin
                r_busy <= 1'b0;
            end
            if (eng_ack) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (solve_go) r_min_size <= i_data.min_size;
        if (eng_ack) r_o_data <= n_o_data;
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;

endmodule
